>>> sv/ssr_pkg.sv
// Shared types and constants for the sparse set with swap-remove block.
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 16;
    localparam int VAL_W     = 64;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 11;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_WRITE   = 2'd2,
        OP_PROCESS = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_MOVE,
        S_DROP,
        S_WALK_RD,
        S_VAL_RD,
        S_VAL_GET,
        S_MUL_SQ,
        S_MUL_A,
        S_MUL_C,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    pos_rd;
        logic    dense_rd_last;
        logic    dense_rd_walk;
        logic    val_rd;
        logic    val_wr;
        logic    add_commit;
        logic    move_commit;
        logic    drop_commit;
        logic    latch_slot;
        logic    clear_wr;
        logic    walk_init;
        logic    walk_inc;
        logic    take_value;
        logic    mul_sq_done;
        logic    mul_a_done;
        logic    mul_c_done;
        logic    set_status;
        t_status status;
        logic    finish;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic pos_valid;
        logic slot_is_last;
        logic count_full;
        logic walk_done;
        logic mul_done;
        logic clear_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> sv/sparse_set_swap_remove_top.sv
// A remove that moves the last member into the freed slot passes through S_MOVE and then
// S_DROP; an add or remove whose index is out of range goes from S_LOOKUP to S_FINISH.
// Process uses one shared 32x32 multiplier, 3 products per member.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset (synchronous, active low) clears the count, then a pass over the position table
// marks every entry invalid; no input transaction is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sparse_set_swap_remove_top #(
    parameter int UNIVERSE = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: index [15:0], value [79:16]
    input  wire logic [ssr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: op [1:0]
    input  wire logic [ssr_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: status [1:0], member_count [12:2], sum [76:13], zero pad [79:77]
    output logic      [ssr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ssr_pkg::*;

    // The controller owns sequencing; every memory access and register update
    // happens in the datapath on its command. The result sits in an output
    // register, so the next transaction is accepted while it waits.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    ssr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssr_datapath #(.UNIVERSE(UNIVERSE)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // The position table has one write port: at most one writer per cycle.
    a_pos_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_wr, cmd.add_commit, cmd.move_commit, cmd.drop_commit}))
        else $error("position table written by two commands in one cycle");

    // After a transaction is taken, the input side closes until it is done.
    a_capture_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !s_axis_tready)
        else $error("input ready right after a capture");

    // A result is never loaded over one that has not been taken.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result register overwritten");

    // A swap-remove moves the last member, then drops the removed index.
    a_move_then_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.move_commit |=> cmd.drop_commit)
        else $error("moved member not followed by a drop");
`endif

endmodule
`default_nettype wire

>>> sv/ssr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/ssr_mul.sv
// Low 64 bits of a 64 by 64 product, one 32 by 32 partial product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ssr_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic      [63:0] o_product
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_p;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_pp;

    always_comb begin
        unique case (r_step)
            STEP_LL: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
            STEP_LH: begin
                w_x = r_a[31:0];
                w_y = r_b[63:32];
            end
            default: begin
                w_x = r_a[63:32];
                w_y = r_b[31:0];
            end
        endcase
        // Both operands are zero-extended 32-bit halves, so the full product fits.
        w_pp = {32'd0, w_x} * {32'd0, w_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                if (r_step == STEP_HL) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            if (r_step == STEP_LL) begin
                r_p <= w_pp;
            end else begin
                r_p[63:32] <= r_p[63:32] + w_pp[31:0];
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule
`default_nettype wire

>>> sv/ssr_datapath.sv
// Datapath: set memories, member count, walk accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module ssr_datapath #(
    parameter int UNIVERSE = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ssr_pkg::t_dp_cmd                i_cmd,
    output ssr_pkg::t_dp_stat                    o_stat,
    input  wire logic [ssr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic [ssr_pkg::OP_W-1:0]        i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [ssr_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import ssr_pkg::*;

    localparam int IW = $clog2(UNIVERSE);
    localparam int CW = $clog2(UNIVERSE + 1);
    localparam logic [IDX_W:0]  UNIV_W   = (IDX_W + 1)'(UNIVERSE);
    localparam logic [CW-1:0]   COUNT_MX = CW'(UNIVERSE);
    localparam logic [IW-1:0]   LAST_IDX = IW'(UNIVERSE - 1);
    localparam int PAD_W = M_TDATA_W - STAT_W - COUNT_W - VAL_W;

    // Request registers.
    t_op               r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_value;

    // Set state and work registers.
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_slot;
    logic [IW-1:0]     r_clr_addr;
    logic [CW-1:0]     r_walk;
    logic [VAL_W-1:0]  r_v;
    logic [VAL_W-1:0]  r_t1;
    logic [VAL_W-1:0]  r_acc;
    t_status           r_status;

    // Result register.
    logic              r_m_valid;
    t_status           r_m_status;
    logic [COUNT_W-1:0] r_m_count;
    logic [VAL_W-1:0]  r_m_sum;

    logic [CW-1:0]     w_last;
    logic              w_pos_we;
    logic [IW-1:0]     w_pos_waddr;
    logic [IW:0]       w_pos_wdata;
    logic [IW:0]       w_pos_rdata;
    logic              w_dense_we;
    logic [IW-1:0]     w_dense_waddr;
    logic [IW-1:0]     w_dense_wdata;
    logic              w_dense_re;
    logic [IW-1:0]     w_dense_raddr;
    logic [IW-1:0]     w_dense_rdata;
    logic [VAL_W-1:0]  w_val_rdata;
    logic              w_mul_start;
    logic [VAL_W-1:0]  w_mul_a;
    logic [VAL_W-1:0]  w_mul_b;
    logic              w_mul_done;
    logic [VAL_W-1:0]  w_mul_p;

    assign w_last = r_count - CW'(1);

    // Position table: valid flag on top of the dense slot.
    always_comb begin
        w_pos_we = i_cmd.clear_wr | i_cmd.add_commit | i_cmd.move_commit
                 | i_cmd.drop_commit;
        priority if (i_cmd.clear_wr) begin
            w_pos_waddr = r_clr_addr;
            w_pos_wdata = '0;
        end else if (i_cmd.add_commit) begin
            w_pos_waddr = r_idx[IW-1:0];
            w_pos_wdata = {1'b1, r_count[IW-1:0]};
        end else if (i_cmd.move_commit) begin
            w_pos_waddr = w_dense_rdata;
            w_pos_wdata = {1'b1, r_slot};
        end else begin
            w_pos_waddr = r_idx[IW-1:0];
            w_pos_wdata = '0;
        end
    end

    always_comb begin
        w_dense_we = i_cmd.add_commit | i_cmd.move_commit;
        if (i_cmd.add_commit) begin
            w_dense_waddr = r_count[IW-1:0];
            w_dense_wdata = r_idx[IW-1:0];
        end else begin
            w_dense_waddr = r_slot;
            w_dense_wdata = w_dense_rdata;
        end
        w_dense_re    = i_cmd.dense_rd_last | i_cmd.dense_rd_walk;
        w_dense_raddr = i_cmd.dense_rd_last ? w_last[IW-1:0] : r_walk[IW-1:0];
    end

    ssr_ram #(.WIDTH(IW + 1), .DEPTH(UNIVERSE)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_waddr),
        .i_wdata (w_pos_wdata),
        .i_re    (i_cmd.pos_rd),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_pos_rdata)
    );

    ssr_ram #(.WIDTH(IW), .DEPTH(UNIVERSE)) u_dense_ram (
        .i_clk   (i_clk),
        .i_we    (w_dense_we),
        .i_waddr (w_dense_waddr),
        .i_wdata (w_dense_wdata),
        .i_re    (w_dense_re),
        .i_raddr (w_dense_raddr),
        .o_rdata (w_dense_rdata)
    );

    ssr_ram #(.WIDTH(VAL_W), .DEPTH(UNIVERSE)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.val_wr),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (r_value),
        .i_re    (i_cmd.val_rd),
        .i_raddr (w_dense_rdata),
        .o_rdata (w_val_rdata)
    );

    // Transform operands: v*v, then (v>>1)*v, then (v*v)*(v>>2).
    always_comb begin
        w_mul_start = i_cmd.take_value | i_cmd.mul_sq_done | i_cmd.mul_a_done;
        priority if (i_cmd.take_value) begin
            w_mul_a = w_val_rdata;
            w_mul_b = w_val_rdata;
        end else if (i_cmd.mul_sq_done) begin
            w_mul_a = {1'b0, r_v[VAL_W-1:1]};
            w_mul_b = r_v;
        end else begin
            w_mul_a = r_t1;
            w_mul_b = {2'b00, r_v[VAL_W-1:2]};
        end
    end

    ssr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cmd.add_commit) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.drop_commit) begin
                r_count <= w_last;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (i_cmd.finish) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_s_tuser);
            r_idx   <= i_s_tdata[IDX_W-1:0];
            r_value <= i_s_tdata[IDX_W +: VAL_W];
        end
        if (i_cmd.latch_slot) begin
            r_slot <= w_pos_rdata[IW-1:0];
        end
        if (i_cmd.walk_init) begin
            r_walk <= '0;
        end else if (i_cmd.walk_inc) begin
            r_walk <= r_walk + CW'(1);
        end
        if (i_cmd.take_value) begin
            r_v <= w_val_rdata;
        end
        if (i_cmd.mul_sq_done) begin
            r_t1 <= w_mul_p;
        end
        priority if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (i_cmd.take_value) begin
            r_acc <= r_acc + w_val_rdata;
        end else if (i_cmd.mul_a_done || i_cmd.mul_c_done) begin
            r_acc <= r_acc + w_mul_p;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.finish) begin
            r_m_status <= r_status;
            r_m_count  <= COUNT_W'(r_count);
            r_m_sum    <= r_acc;
        end
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.in_range     = {1'b0, r_idx} < UNIV_W;
        o_stat.pos_valid    = w_pos_rdata[IW];
        o_stat.slot_is_last = CW'(w_pos_rdata[IW-1:0]) == w_last;
        o_stat.count_full   = r_count == COUNT_MX;
        o_stat.walk_done    = r_walk == r_count;
        o_stat.mul_done     = w_mul_done;
        o_stat.clear_done   = r_clr_addr == LAST_IDX;
        o_stat.out_free     = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_m_sum, r_m_count, r_m_status};

endmodule
`default_nettype wire

>>> sv/ssr_ctrl.sv
// Controller state machine sequencing add, remove, write and process.
`timescale 1ns / 1ps
`default_nettype none
module ssr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire ssr_pkg::t_dp_stat i_stat,
    output ssr_pkg::t_dp_cmd       o_cmd
);
    import ssr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                priority if (i_stat.op == OP_PROCESS) begin
                    n_state = S_WALK_RD;
                end else if (!i_stat.in_range || i_stat.op == OP_WRITE) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.op == OP_ADD || !i_stat.pos_valid
                             || i_stat.slot_is_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE:    n_state = S_DROP;
            S_DROP:    n_state = S_FINISH;
            S_WALK_RD: n_state = i_stat.walk_done ? S_FINISH : S_VAL_RD;
            S_VAL_RD:  n_state = S_VAL_GET;
            S_VAL_GET: n_state = S_MUL_SQ;
            S_MUL_SQ: begin
                if (i_stat.mul_done) n_state = S_MUL_A;
            end
            S_MUL_A: begin
                if (i_stat.mul_done) n_state = S_MUL_C;
            end
            S_MUL_C: begin
                if (i_stat.mul_done) n_state = S_WALK_RD;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_DONE;
        o_s_tready   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_LOOKUP: begin
                o_cmd.set_status = 1'b1;
                priority if (i_stat.op == OP_PROCESS) begin
                    o_cmd.walk_init = 1'b1;
                end else if (!i_stat.in_range) begin
                    o_cmd.status = ST_RANGE;
                end else if (i_stat.op == OP_WRITE) begin
                    o_cmd.val_wr = 1'b1;
                end else begin
                    o_cmd.pos_rd = 1'b1;
                end
            end
            S_CHECK: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.op == OP_ADD) begin
                    if (i_stat.pos_valid || i_stat.count_full) begin
                        o_cmd.status = ST_NO_CHANGE;
                    end else begin
                        o_cmd.add_commit = 1'b1;
                    end
                end else begin
                    if (!i_stat.pos_valid) begin
                        o_cmd.status = ST_NO_CHANGE;
                    end else if (i_stat.slot_is_last) begin
                        o_cmd.drop_commit = 1'b1;
                    end else begin
                        o_cmd.latch_slot    = 1'b1;
                        o_cmd.dense_rd_last = 1'b1;
                    end
                end
            end
            S_MOVE: begin
                o_cmd.move_commit = 1'b1;
            end
            S_DROP: begin
                o_cmd.drop_commit = 1'b1;
            end
            S_WALK_RD: begin
                o_cmd.dense_rd_walk = !i_stat.walk_done;
            end
            S_VAL_RD: begin
                o_cmd.val_rd = 1'b1;
            end
            S_VAL_GET: begin
                o_cmd.take_value = 1'b1;
            end
            S_MUL_SQ: begin
                o_cmd.mul_sq_done = i_stat.mul_done;
            end
            S_MUL_A: begin
                o_cmd.mul_a_done = i_stat.mul_done;
            end
            S_MUL_C: begin
                o_cmd.mul_c_done = i_stat.mul_done;
                o_cmd.walk_inc   = i_stat.mul_done;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
